FILE: hdl/b64sc_pkg.sv
`default_nettype none
package b64sc_pkg;

  // register map
  localparam int unsigned NUM_REGS = 1;
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam int unsigned CFG_AW = 3;

  // results of one item and the result queue
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned RES_FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW = $clog2(RES_FIFO_DEPTH);
  localparam int unsigned FIFO_CW = $clog2(RES_FIFO_DEPTH + 1);

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [3:0] BAL_ENC_INIT = 4'b1010;  // -6
  localparam logic [3:0] BAL_DEC_INIT = 4'b1000;  // -8

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] symbol;
    logic       empty_res;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [RES_CNT_W-1:0]        count;
    out_item_t [MAX_RES-1:0]     item;
  } res_push_t;

  typedef struct packed {
    logic wr;
    logic mode;
  } cfg_cmd_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    priority if (v < 6'd26) begin
      return w + 8'd65;
    end else if (v < 6'd52) begin
      return w + 8'd71;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // character to {in alphabet, 6-bit value}
  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    priority if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'd65;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'd71;
      return {1'b1, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'd4;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end else begin
      return 7'd0;
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/b64sc_core.sv
`default_nettype none
module b64sc_core import b64sc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      mode,
  input  wire cfg_cmd_t  cfg,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  input  wire logic      fifo_room,
  output res_push_t      push
);

  localparam logic [4:0] B_M4 = 5'b11100;
  localparam logic [4:0] B_M6 = 5'b11010;

  logic       s0_valid_r, s0_valid_nxt;
  in_item_t   s0_item_r;
  logic [11:0] acc_r, acc_nxt;
  logic [3:0]  bal_r, bal_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        pad_r, pad_nxt;
  logic        load, advance;
  out_item_t [MAX_RES-1:0] items;
  logic [RES_CNT_W-1:0] n;

  assign advance  = s0_valid_r && fifo_room;
  assign in_stall = s0_valid_r && !fifo_room;
  assign load     = in_valid && !in_stall;
  assign s0_valid_nxt = load || (s0_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      acc_r      <= '0;
      bal_r      <= BAL_ENC_INIT;
      phase_r    <= '0;
      pad_r      <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      acc_r      <= acc_nxt;
      bal_r      <= bal_nxt;
      phase_r    <= phase_nxt;
      pad_r      <= pad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s0_item_r <= in_data;
    end
  end

  always_comb begin
    logic [11:0] acc_n;
    logic [11:0] sh;
    logic [4:0]  b;
    logic [1:0]  ph;
    logic [6:0]  cv;
    logic [7:0]  c;
    logic [1:0]  lidx;
    logic        eos;
    c       = s0_item_r.data_byte;
    eos     = s0_item_r.end_of_stream;
    items   = '0;
    n       = '0;
    acc_n   = acc_r;
    sh      = '0;
    b       = {bal_r[3], bal_r};
    ph      = phase_r;
    cv      = '0;
    lidx    = '0;
    acc_nxt   = acc_r;
    bal_nxt   = bal_r;
    phase_nxt = phase_r;
    pad_nxt   = pad_r;
    if (!mode) begin
      // encode: one or two symbols, then tail and padding at end of stream
      acc_n = {acc_r[3:0], c};
      b     = b + 5'd8;
      sh    = acc_n >> b[2:0];
      items[0].symbol = b64_char(sh[5:0]);
      n  = RES_CNT_W'(1);
      ph = ph + 2'd1;
      b  = b - 5'd6;
      if (!b[4]) begin
        items[1].symbol = b64_char(acc_n[5:0]);
        n  = RES_CNT_W'(2);
        ph = ph + 2'd1;
        b  = B_M6;
      end
      if (eos) begin
        if (b != B_M6) begin
          if (b == B_M4) begin
            items[n[1:0]].symbol = b64_char({acc_n[1:0], 4'b0000});
          end else begin
            items[n[1:0]].symbol = b64_char({acc_n[3:0], 2'b00});
          end
          n  = n + RES_CNT_W'(1);
          ph = ph + 2'd1;
        end
        for (int k = 0; k < MAX_RES; k++) begin
          if (ph != 2'd0 && n < RES_CNT_W'(MAX_RES)) begin
            items[n[1:0]].symbol = PAD_CHAR;
            n  = n + RES_CNT_W'(1);
            ph = ph + 2'd1;
          end
        end
        lidx = n[1:0] - 2'd1;
        items[lidx].last = 1'b1;
        acc_nxt   = '0;
        bal_nxt   = BAL_ENC_INIT;
        phase_nxt = '0;
        pad_nxt   = 1'b0;
      end else begin
        acc_nxt   = acc_n;
        bal_nxt   = b[3:0];
        phase_nxt = ph;
      end
    end else begin
      // decode: gather six bits per character, a byte per eight bits
      if (!pad_r) begin
        cv = b64_value(c);
        if (cv[6]) begin
          acc_n = {acc_r[5:0], cv[5:0]};
          b     = b + 5'd6;
          if (!b[4]) begin
            sh = acc_n >> b[2:0];
            items[0].symbol = sh[7:0];
            n = RES_CNT_W'(1);
            b = b - 5'd8;
          end
        end else if (c == PAD_CHAR) begin
          pad_nxt = 1'b1;
        end
      end
      if (eos) begin
        if (n == '0) begin
          items[0].empty_res = 1'b1;
          n = RES_CNT_W'(1);
        end
        items[0].last = 1'b1;
        acc_nxt   = '0;
        bal_nxt   = BAL_DEC_INIT;
        phase_nxt = '0;
        pad_nxt   = 1'b0;
      end else begin
        acc_nxt = acc_n;
        bal_nxt = b[3:0];
      end
    end
    if (!advance) begin
      acc_nxt   = acc_r;
      bal_nxt   = bal_r;
      phase_nxt = phase_r;
      pad_nxt   = pad_r;
    end
    if (cfg.wr) begin
      acc_nxt   = '0;
      bal_nxt   = cfg.mode ? BAL_DEC_INIT : BAL_ENC_INIT;
      phase_nxt = '0;
      pad_nxt   = 1'b0;
    end
  end

  assign push.count = advance ? n : '0;
  assign push.item  = items;

endmodule
`default_nettype wire

FILE: hdl/b64sc_fifo.sv
`default_nettype none
module b64sc_fifo import b64sc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire res_push_t push,
  output logic           fifo_room,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  out_item_t          mem_r [RES_FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;
  logic               pop;

  assign out_valid = count_r != '0;
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for the largest burst of one item
  assign fifo_room = count_r <= FIFO_CW'(RES_FIFO_DEPTH - MAX_RES);

  assign wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.count);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
  assign count_nxt  = count_r + FIFO_CW'(push.count) - FIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (RES_CNT_W'(k) < push.count) begin
        mem_r[wr_ptr_r + FIFO_AW'(k)] <= push.item[k];
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/base64_stream_codec_top.sv
`default_nettype none
// the first result of an item passes the input register and the result queue before it is offered
// throughput: one input per cycle while the 8-entry result queue has room for 4
// sustained rate is set by the single output port, one result per cycle while out_stall is low:
// about 4/3 results per byte encoding (up to 4 on a last byte), at most one decoding
// reset: synchronous active-low rst_n empties the queue, selects encode, clears stream state
module base64_stream_codec_top import b64sc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic      decode_mode_r, decode_mode_nxt;
  logic      reg_idx;
  cfg_cmd_t  cfg;
  res_push_t push;
  logic      fifo_room;

  // register index is the word address; bit 2 past the only register
  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  // a mode write restarts the stream in the chosen direction
  assign cfg.wr   = psel && penable && pwrite && (reg_idx == REG_DECODE_MODE);
  assign cfg.mode = pwdata[0];
  assign decode_mode_nxt = cfg.wr ? pwdata[0] : decode_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
    end else begin
      decode_mode_r <= decode_mode_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_DECODE_MODE) begin
      prdata[0] = decode_mode_r;
    end
  end

  // input register, stream state and per-item symbol logic
  b64sc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (decode_mode_r),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .fifo_room (fifo_room),
    .push      (push)
  );

  // result queue, one transfer out per cycle while out_stall is low
  b64sc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fifo_room (fifo_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // decoding yields at most one result per item
  a_dec_single: assert property (@(posedge clk) disable iff (!rst_n)
    decode_mode_r |-> (push.count <= RES_CNT_W'(1)))
    else $error("decode pushed more than one result");

  // an end mark on the first result of a push means the push holds only that result
  a_last_first: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != '0 && push.item[0].last) |-> (push.count == RES_CNT_W'(1)))
    else $error("last flag not on final result");

  // encoding never produces an empty result
  a_enc_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (!decode_mode_r && push.count != '0) |-> !push.item[0].empty_res)
    else $error("empty result while encoding");

  // nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_base64_stream_codec_top.sv
`default_nettype none
module tb_base64_stream_codec_top;
  import b64sc_pkg::*;

  // direction codes held in the mode register
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // byte address of the mode register
  localparam logic [CFG_AW-1:0] MODE_ADDR = CFG_AW'(4 * int'(REG_DECODE_MODE));

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;

  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  base64_stream_codec_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // bytes waiting to be sent, and the stream being assembled before it is queued
  in_item_t  pending_bytes[$];
  in_item_t  stream_stage[$];
  // predicted codec output, oldest first
  out_item_t expected_syms[$];

  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned n_err = 0;
  int unsigned cycles = 0;
  bit          idle_en = 1'b1;

  // codec state as the predictor sees it
  logic        m_mode;
  logic [11:0] m_acc;
  int          m_bal;
  logic [1:0]  m_phase;
  bit          m_pad;

  // 6-bit value to base64 character
  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) return 8'h41 + w;
    else if (v < 6'd52) return 8'h61 + w - 8'd26;
    else if (v < 6'd62) return 8'h30 + w - 8'd52;
    else if (v == 6'd62) return 8'h2B;
    else return 8'h2F;
  endfunction

  // base64 character to its value, -1 outside the alphabet
  function automatic int char_val(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    else if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    else if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    else if (c == 8'h2B) return 62;
    else if (c == 8'h2F) return 63;
    else return -1;
  endfunction

  function automatic void clear_stream();
    m_acc = '0;
    m_bal = (m_mode == MODE_DECODE) ? -8 : -6;
    m_phase = '0;
    m_pad = 1'b0;
  endfunction

  // works out the results of one transfer and queues them
  function automatic void predict_codec(input in_item_t it);
    out_item_t   res[$];
    out_item_t   o;
    logic [11:0] tmp;
    int          v;
    if (m_mode == MODE_ENCODE) begin
      m_acc = {m_acc[3:0], it.data_byte};
      m_bal = m_bal + 8;
      while (m_bal >= 0) begin
        tmp = m_acc >> m_bal;
        o = '{symbol: sym_char(tmp[5:0]), empty_res: 1'b0, last: 1'b0};
        res = {res, o};
        m_phase = m_phase + 2'd1;
        m_bal = m_bal - 6;
      end
      if (it.end_of_stream) begin
        // leftover bits, zero filled on the right
        if (m_bal > -6) begin
          tmp = m_acc << (-m_bal);
          o = '{symbol: sym_char(tmp[5:0]), empty_res: 1'b0, last: 1'b0};
          res = {res, o};
          m_phase = m_phase + 2'd1;
        end
        // pad the symbol count up to a multiple of four
        while (m_phase != 2'd0 && res.size() < 4) begin
          o = '{symbol: PAD_CHAR, empty_res: 1'b0, last: 1'b0};
          res = {res, o};
          m_phase = m_phase + 2'd1;
        end
        res[res.size() - 1].last = 1'b1;
        clear_stream();
      end
    end else begin
      if (!m_pad) begin
        v = char_val(it.data_byte);
        if (v >= 0) begin
          m_acc = {m_acc[5:0], v[5:0]};
          m_bal = m_bal + 6;
          if (m_bal >= 0) begin
            tmp = m_acc >> m_bal;
            o = '{symbol: tmp[7:0], empty_res: 1'b0, last: 1'b0};
            res = {res, o};
            m_bal = m_bal - 8;
          end
        end else if (it.data_byte == PAD_CHAR) begin
          // everything after the first pad is dropped until end of stream
          m_pad = 1'b1;
        end
      end
      if (it.end_of_stream) begin
        // nothing decoded on the last character: a marker result closes the stream
        if (res.size() == 0) begin
          o = '{symbol: 8'h00, empty_res: 1'b1, last: 1'b1};
          res = {res, o};
        end else begin
          res[0].last = 1'b1;
        end
        clear_stream();
      end
    end
    expected_syms = {expected_syms, res};
  endfunction

  function automatic void note_error(input string msg);
    n_err++;
    if (n_err <= MAX_REPORTS) $display("error at cycle %0d: %s", cycles, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds the input channel from pending_bytes, idles in random bursts
  // ---------------------------------------------------------------------------
  int unsigned in_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      // a transfer happened at this edge: predict its results now
      if (in_valid && !in_stall) begin
        predict_codec(in_data);
        n_accepted++;
      end
      // payload may only move when nothing is held by a stall
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          if (idle_en && $urandom_range(0, 7) == 0) begin
            // burst of idle cycles of random length, this one included
            in_gap <= $urandom_range(0, 11);
            in_valid <= 1'b0;
          end else begin
            in_data <= pending_bytes.pop_front();
            in_valid <= 1'b1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result transfer, stalls the result channel in bursts
  // ---------------------------------------------------------------------------
  int unsigned out_gap = 0;
  out_item_t   want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_syms.size() == 0) begin
          note_error($sformatf("result with nothing expected: symbol %02h empty %0b last %0b",
                               out_data.symbol, out_data.empty_res, out_data.last));
        end else begin
          want = expected_syms.pop_front();
          if (out_data.symbol !== want.symbol || out_data.empty_res !== want.empty_res ||
              out_data.last !== want.last) begin
            note_error($sformatf("expected symbol %02h empty %0b last %0b, got %02h %0b %0b",
                                 want.symbol, want.empty_res, want.last,
                                 out_data.symbol, out_data.empty_res, out_data.last));
          end
        end
      end
      if (!idle_en) begin
        out_gap <= 0;
        out_stall <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("base64_stream_codec_top: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic stage(input logic [7:0] b);
    in_item_t it;
    it.data_byte = b;
    it.end_of_stream = 1'b0;
    stream_stage = {stream_stage, it};
  endtask

  // hand the staged bytes to the driver, optionally closing the stream
  task automatic flush_stage(input bit close);
    if (close && stream_stage.size() > 0)
      stream_stage[stream_stage.size() - 1].end_of_stream = 1'b1;
    pending_bytes = {pending_bytes, stream_stage};
    n_queued += stream_stage.size();
    stream_stage.delete();
  endtask

  // sender holds off until every transfer is in and every result is out,
  // then lets the pipeline settle in case the last item made no result
  task automatic wait_idle();
    while (!(n_accepted == n_queued && expected_syms.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one apb transfer: setup cycle, then access until pready
  task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MODE_ADDR;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // write the mode register, follow it in the predictor, read it back
  task automatic set_mode(input logic m);
    logic [31:0] rd;
    apb_xfer(1'b1, {31'd0, m}, rd);
    m_mode = m;
    clear_stream();
    apb_xfer(1'b0, 32'd0, rd);
    if (rd !== {31'd0, m})
      note_error($sformatf("mode readback expected %08h, got %08h", {31'd0, m}, rd));
  endtask

  task automatic stage_enc_stream();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    repeat (len) stage(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed quads with random content, some noise and broken groups
  task automatic stage_dec_stream();
    int nq;
    int npad;
    nq = $urandom_range(1, 3);
    npad = $urandom_range(0, 2);
    for (int q = 0; q < nq; q++) begin
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 11) == 0) stage(8'($urandom_range(0, 255)));
        if (q == nq - 1 && k >= 4 - npad) stage(PAD_CHAR);
        else if ($urandom_range(0, 15) != 0) stage(sym_char(6'($urandom_range(0, 63))));
      end
    end
    // trailing characters after padding
    if (npad > 0 && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) stage(sym_char(6'($urandom_range(0, 63))));
    end
    // occasionally end on a stray character
    if ($urandom_range(0, 7) == 0) stage(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] rd;
    int unsigned phase_start;
    bit paused;

    m_mode = MODE_ENCODE;
    clear_stream();
    paused = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // register comes out of reset in encode
    apb_xfer(1'b0, 32'd0, rd);
    if (rd !== {31'd0, MODE_ENCODE})
      note_error($sformatf("mode after reset expected encode, got %08h", rd));

    // encode: one, two and three byte streams give two, one and no pads
    set_mode(MODE_ENCODE);
    stage(8'h00);
    flush_stage(1'b1);
    stage(8'hFF); stage(8'hFF);
    flush_stage(1'b1);
    stage(8'h00); stage(8'hFF); stage(8'h80);
    flush_stage(1'b1);
    // stream left open, then a mode write has to drop it
    stage(8'h41);
    flush_stage(1'b0);
    wait_idle();

    // decode: alphabet boundaries, padding, a stream ending with no byte
    set_mode(MODE_DECODE);
    stage(8'h41); stage(8'h5A); stage(8'h61); stage(8'h7A);
    stage(8'h30); stage(8'h39); stage(8'h2B); stage(8'h2F);
    flush_stage(1'b1);
    stage(8'h54); stage(8'h51); stage(PAD_CHAR); stage(PAD_CHAR);
    flush_stage(1'b1);
    // single character outside the alphabet
    stage(8'hFF);
    flush_stage(1'b1);
    // data after a pad is ignored
    stage(PAD_CHAR); stage(8'h41);
    flush_stage(1'b1);
    // open stream, cleared by rewriting the same mode
    stage(8'h51);
    flush_stage(1'b0);
    wait_idle();
    set_mode(MODE_DECODE);

    // random phases alternate direction; the last one runs without idling
    for (int ph = 0; ph < 6; ph++) begin
      set_mode(ph[0] ? MODE_DECODE : MODE_ENCODE);
      phase_start = n_queued;
      while (n_queued - phase_start < 60) begin
        idle_en = (ph != 5) && ($urandom_range(0, 3) != 0);
        if (ph == 2 && !paused && n_queued - phase_start >= 30) begin
          // sender waits for the codec to drain in the middle of a stream
          repeat (3) stage(8'($urandom_range(0, 255)));
          flush_stage(1'b0);
          wait_idle();
          paused = 1'b1;
        end
        if (m_mode == MODE_ENCODE) stage_enc_stream();
        else stage_dec_stream();
        flush_stage(1'b1);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (n_err == 0 && expected_syms.size() == 0) begin
      $display("base64_stream_codec_top: match");
    end else begin
      $display("base64_stream_codec_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
